@@ sv/ism_pkg.sv @@
package ism_pkg;

  localparam logic [7:0] OP_NOP     = 8'h00;
  localparam logic [7:0] OP_PUSH32  = 8'h01;
  localparam logic [7:0] OP_PUSH64  = 8'h02;
  localparam logic [7:0] OP_PUSHREG = 8'h03;
  localparam logic [7:0] OP_POPREG  = 8'h04;
  localparam logic [7:0] OP_DUP     = 8'h05;
  localparam logic [7:0] OP_ADD     = 8'h20;
  localparam logic [7:0] OP_SUB     = 8'h21;
  localparam logic [7:0] OP_MUL     = 8'h22;
  localparam logic [7:0] OP_DIV     = 8'h23;
  localparam logic [7:0] OP_MOD     = 8'h24;
  localparam logic [7:0] OP_SHL     = 8'h25;
  localparam logic [7:0] OP_SHR     = 8'h26;
  localparam logic [7:0] OP_SAR     = 8'h27;
  localparam logic [7:0] OP_AND     = 8'h30;
  localparam logic [7:0] OP_OR      = 8'h31;
  localparam logic [7:0] OP_XOR     = 8'h32;
  localparam logic [7:0] OP_NOT     = 8'h33;
  localparam logic [7:0] OP_EQ      = 8'h40;
  localparam logic [7:0] OP_NE      = 8'h41;
  localparam logic [7:0] OP_SLT     = 8'h42;
  localparam logic [7:0] OP_SLE     = 8'h43;
  localparam logic [7:0] OP_SGT     = 8'h44;
  localparam logic [7:0] OP_SGE     = 8'h45;
  localparam logic [7:0] OP_ULT     = 8'h46;
  localparam logic [7:0] OP_ULE     = 8'h47;
  localparam logic [7:0] OP_UGT     = 8'h48;
  localparam logic [7:0] OP_UGE     = 8'h49;
  localparam logic [7:0] OP_JMP     = 8'h51;
  localparam logic [7:0] OP_JZ      = 8'h52;
  localparam logic [7:0] OP_JNZ     = 8'h53;
  localparam logic [7:0] OP_CALL    = 8'h56;
  localparam logic [7:0] OP_RET     = 8'h57;
  localparam logic [7:0] OP_HALT    = 8'hFF;
  localparam logic [7:0] OP_PRELOAD = 8'hF0;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_UNDER = 2'd1;
  localparam logic [1:0] FAULT_OVER  = 2'd2;
  localparam logic [1:0] FAULT_ILL   = 2'd3;

  localparam logic [1:0] MD_MUL = 2'd0;
  localparam logic [1:0] MD_DIV = 2'd1;
  localparam logic [1:0] MD_MOD = 2'd2;

  typedef struct packed {
    logic [7:0]  mode;
    logic [63:0] immediate;
    logic [7:0]  reg_index;
  } item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [63:0] top_value;
    logic [10:0] depth;
    logic        halted;
    logic [63:0] final_value;
    logic [1:0]  fault;
  } result_t;

  typedef struct packed {
    logic       legal;
    logic [3:0] len;
    logic [1:0] need;
    logic       grow;
  } cls_t;

  typedef struct packed {
    item_t item;
    cls_t  cls;
  } dec_t;

  function automatic cls_t ism_classify(input logic [7:0] op);
    cls_t c;
    c = '{legal: 1'b1, len: 4'd1, need: 2'd0, grow: 1'b0};
    case (op)
      OP_NOP, OP_HALT, OP_RET: ;
      OP_PUSH32:  begin c.len = 4'd5; c.grow = 1'b1; end
      OP_PUSH64:  begin c.len = 4'd9; c.grow = 1'b1; end
      OP_PUSHREG: begin c.len = 4'd2; c.grow = 1'b1; end
      OP_POPREG:  begin c.len = 4'd2; c.need = 2'd1; end
      OP_DUP:     begin c.need = 2'd1; c.grow = 1'b1; end
      OP_NOT:     c.need = 2'd1;
      OP_JMP:     c.len = 4'd5;
      OP_JZ, OP_JNZ: begin c.len = 4'd5; c.need = 2'd1; end
      OP_CALL:    begin c.len = 4'd5; c.grow = 1'b1; end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SHL, OP_SHR, OP_SAR,
      OP_AND, OP_OR, OP_XOR, OP_EQ, OP_NE, OP_SLT, OP_SLE, OP_SGT, OP_SGE,
      OP_ULT, OP_ULE, OP_UGT, OP_UGE: c.need = 2'd2;
      default: c.legal = 1'b0;
    endcase
    return c;
  endfunction

  function automatic logic [63:0] ism_binop(input logic [7:0] op, input logic [63:0] a,
                                            input logic [63:0] b);
    logic [5:0] sh;
    sh = b[5:0];
    case (op)
      OP_ADD: return a + b;
      OP_SUB: return a - b;
      OP_SHL: return a << sh;
      OP_SHR: return a >> sh;
      OP_SAR: return $unsigned($signed(a) >>> sh);
      OP_AND: return a & b;
      OP_OR:  return a | b;
      OP_XOR: return a ^ b;
      OP_EQ:  return {63'd0, a == b};
      OP_NE:  return {63'd0, a != b};
      OP_SLT: return {63'd0, $signed(a) < $signed(b)};
      OP_SLE: return {63'd0, $signed(a) <= $signed(b)};
      OP_SGT: return {63'd0, $signed(a) > $signed(b)};
      OP_SGE: return {63'd0, $signed(a) >= $signed(b)};
      OP_ULT: return {63'd0, a < b};
      OP_ULE: return {63'd0, a <= b};
      OP_UGT: return {63'd0, a > b};
      default: return {63'd0, a >= b};
    endcase
  endfunction

endpackage

@@ sv/integer_stack_machine_core.sv @@
// channel  | direction | transfer when          | payload
// input    | in        | push && !full          | item (item_t)
// result   | out       | pop && !empty          | result (result_t)
// config   | in        | cfg_valid && cfg_ready | cfg_data (program_length)
//
// Each instruction passes idle then execute, through the stack RAM read then
// write; multiply, divide and modulo also wait in a wait state on the shared
// iterative unit. Reset clears counters, registers and program length; stack
// contents are not cleared. Either queue side may stall independently.
module integer_stack_machine_core
  import ism_pkg::*;
#(
  parameter int STACK_DEPTH = 1024,
  parameter int REG_COUNT   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  item_t       item,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  logic [15:0] program_length;
  logic        q_empty, q_pop, o_full, o_push;
  dec_t        q_data;
  result_t     o_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (cfg_valid) begin
      program_length <= cfg_data;
    end
  end

  ism_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .full    (full),
    .q_pop   (q_pop),
    .q_data  (q_data),
    .q_empty (q_empty)
  );

  ism_back #(.STACK_DEPTH(STACK_DEPTH), .REG_COUNT(REG_COUNT)) u_back (
    .clk            (clk),
    .rst            (rst),
    .program_length (program_length),
    .q_empty        (q_empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .o_full         (o_full),
    .o_push         (o_push),
    .o_data         (o_data)
  );

  ism_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_out (
    .clk   (clk),
    .rst   (rst),
    .wr    (o_push),
    .wdata (o_data),
    .full  (o_full),
    .rd    (pop),
    .rdata (result),
    .empty (empty)
  );
endmodule

@@ sv/ism_ram.sv @@
module ism_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/ism_fifo.sv @@
module ism_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PW-1:0]    head, tail;
  logic [CW-1:0]    count;
  logic             do_wr, do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slot[head];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot[tail] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        tail <= (tail == PW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (do_rd) begin
        head <= (head == PW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

@@ sv/ism_front.sv @@
module ism_front
  import ism_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t item,
  output logic  full,
  input  logic  q_pop,
  output dec_t  q_data,
  output logic  q_empty
);
  dec_t dec;

  assign dec.item = item;
  assign dec.cls  = ism_classify(item.mode);

  ism_fifo #(.WIDTH($bits(dec_t)), .DEPTH(2)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wdata (dec),
    .full  (full),
    .rd    (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );
endmodule

@@ sv/ism_muldiv.sv @@
module ism_muldiv
  import ism_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  kind,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] result
);
  logic        busy;
  logic [1:0]  op;
  logic [6:0]  step;
  logic [63:0] x, y;
  logic [63:0] acc;
  logic [64:0] rem;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [64:0] trial;

  always_comb begin
    unique case (step[1:0])
      2'd0:    begin ma = x[31:0];  mb = y[31:0];  end
      2'd1:    begin ma = x[31:0];  mb = y[63:32]; end
      default: begin ma = x[63:32]; mb = y[31:0];  end
    endcase
  end

  assign prod   = ma * mb;
  assign trial  = {rem[63:0], acc[63]};
  assign result = (op == MD_MOD) ? rem[63:0] : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        op   <= kind;
        x    <= a;
        y    <= b;
        step <= '0;
        acc  <= (kind == MD_MUL) ? 64'd0 : a;
        rem  <= '0;
      end else if (busy) begin
        if (op == MD_MUL) begin
          step <= step + 1'b1;
          if (step[1:0] == 2'd0) begin
            acc <= prod;
          end else begin
            acc <= acc + {prod[31:0], 32'd0};
          end
          if (step[1:0] == 2'd2) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else if (y == 64'd0) begin
          acc  <= '0;
          rem  <= '0;
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
          if (trial >= {1'b0, y}) begin
            rem <= trial - {1'b0, y};
            acc <= {acc[62:0], 1'b1};
          end else begin
            rem <= trial;
            acc <= {acc[62:0], 1'b0};
          end
          if (step == 7'd63) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end
endmodule

@@ sv/ism_back.sv @@
module ism_back
  import ism_pkg::*;
#(
  parameter int STACK_DEPTH = 1024,
  parameter int REG_COUNT   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] program_length,
  input  logic        q_empty,
  input  dec_t        q_data,
  output logic        q_pop,
  input  logic        o_full,
  output logic        o_push,
  output result_t     o_data
);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int RW = $clog2(REG_COUNT);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]    state;
  dec_t          cur;
  logic [CW-1:0] count, count_next;
  logic [63:0]   tos, tos_next;
  logic [31:0]   pc, pc_next;
  logic          stopped, stopped_next;
  logic [63:0]   regs [REG_COUNT];

  logic [63:0]   rd;
  logic          we;
  logic [AW-1:0] waddr;
  logic [63:0]   wdata;
  logic          rwe;
  logic [63:0]   rwval;

  logic [7:0]    op;
  logic [63:0]   imm;
  logic [7:0]    ri;
  logic [RW-1:0] ridx;
  logic          ri_in, ri_ok;
  logic [31:0]   after, off, target;
  logic [1:0]    fault;
  logic          active, is_md, md_start, md_done, commit;
  logic [1:0]    md_kind;
  logic [63:0]   md_result, alu, rval, r1_next, top_next;

  assign op    = cur.item.mode;
  assign imm   = cur.item.immediate;
  assign ri    = cur.item.reg_index;
  assign ridx  = ri[RW-1:0];
  assign ri_in = (ri < 8'(REG_COUNT));
  assign ri_ok = ri_in && (ri != 8'd0);
  assign rval  = ri_in ? regs[ridx] : 64'd0;
  assign after = pc + {28'd0, cur.cls.len};
  assign off   = imm[31:0];
  assign target = after + off;

  always_comb begin
    if (!cur.cls.legal) begin
      fault = FAULT_ILL;
    end else if (count < {{(CW-2){1'b0}}, cur.cls.need}) begin
      fault = FAULT_UNDER;
    end else if (cur.cls.grow && count >= CW'(STACK_DEPTH)) begin
      fault = FAULT_OVER;
    end else begin
      fault = FAULT_NONE;
    end
  end

  assign active = (op != OP_PRELOAD) && !stopped && (pc >= {16'd0, program_length} ? 1'b0 : 1'b1);
  assign is_md  = (op == OP_MUL) || (op == OP_DIV) || (op == OP_MOD);
  assign md_kind = (op == OP_MUL) ? MD_MUL : ((op == OP_DIV) ? MD_DIV : MD_MOD);
  assign md_start = (state == S_EXEC) && active && (fault == FAULT_NONE) && is_md;
  assign commit = ((state == S_EXEC) && !md_start) || ((state == S_WAIT) && md_done);
  assign alu = is_md ? md_result : ism_binop(op, rd, tos);

  ism_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (md_start),
    .kind   (md_kind),
    .a      (rd),
    .b      (tos),
    .done   (md_done),
    .result (md_result)
  );

  ism_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (AW'(count - CW'(2))),
    .rdata (rd)
  );

  always_comb begin
    count_next   = count;
    tos_next     = tos;
    pc_next      = pc;
    stopped_next = stopped;
    we           = 1'b0;
    waddr        = AW'(count);
    wdata        = 64'd0;
    rwe          = 1'b0;
    rwval        = 64'd0;
    if (op == OP_PRELOAD) begin
      rwe   = ri_ok;
      rwval = imm;
    end else if (stopped) begin
      stopped_next = 1'b1;
    end else if (!active) begin
      stopped_next = 1'b1;
    end else if (fault != FAULT_NONE) begin
      pc_next      = after;
      stopped_next = 1'b1;
    end else begin
      pc_next = after;
      case (op)
        OP_HALT: stopped_next = 1'b1;
        OP_PUSH32, OP_PUSH64, OP_PUSHREG, OP_DUP, OP_CALL: begin
          unique case (op)
            OP_PUSH32:  wdata = {32'd0, imm[31:0]};
            OP_PUSH64:  wdata = imm;
            OP_PUSHREG: wdata = rval;
            OP_DUP:     wdata = tos;
            default:    wdata = {32'd0, after};
          endcase
          we         = 1'b1;
          waddr      = AW'(count);
          tos_next   = wdata;
          count_next = count + 1'b1;
          if (op == OP_CALL) begin
            pc_next = target;
          end
        end
        OP_POPREG: begin
          count_next = count - 1'b1;
          tos_next   = rd;
          rwe        = ri_ok;
          rwval      = tos;
        end
        OP_NOT: begin
          we       = 1'b1;
          waddr    = AW'(count - 1'b1);
          wdata    = ~tos;
          tos_next = ~tos;
        end
        OP_JMP: pc_next = target;
        OP_JZ, OP_JNZ: begin
          count_next = count - 1'b1;
          tos_next   = rd;
          if ((tos == 64'd0) == (op == OP_JZ)) begin
            pc_next = target;
          end
        end
        OP_RET: begin
          if (count != '0) begin
            count_next = count - 1'b1;
            tos_next   = rd;
            pc_next    = tos[31:0];
          end else begin
            stopped_next = 1'b1;
          end
        end
        OP_NOP: ;
        default: begin
          we         = 1'b1;
          waddr      = AW'(count - CW'(2));
          wdata      = alu;
          tos_next   = alu;
          count_next = count - 1'b1;
        end
      endcase
      if (pc_next >= {16'd0, program_length}) begin
        stopped_next = 1'b1;
      end
    end
    we = we && commit;
  end

  assign r1_next  = (rwe && ri == 8'd1) ? rwval : regs[1];
  assign top_next = (count_next != '0) ? tos_next : 64'd0;

  always_comb begin
    o_data.next_pc     = pc_next;
    o_data.top_value   = top_next;
    o_data.depth       = 11'(count_next);
    o_data.halted      = stopped_next;
    o_data.final_value = stopped_next ? ((count_next != '0) ? top_next : r1_next) : 64'd0;
    o_data.fault       = (active && op != OP_PRELOAD) ? fault : FAULT_NONE;
  end

  assign o_push = commit;
  assign q_pop  = (state == S_IDLE) && !q_empty && !o_full;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      tos     <= '0;
      pc      <= '0;
      stopped <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        regs[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: if (q_pop) state <= S_EXEC;
        S_EXEC: state <= md_start ? S_WAIT : S_IDLE;
        S_WAIT: if (md_done) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (commit) begin
        count   <= count_next;
        tos     <= tos_next;
        pc      <= pc_next;
        stopped <= stopped_next;
        if (rwe) begin
          regs[ridx] <= rwval;
        end
      end
    end
  end
endmodule
